// File: hdl/rne_pkg.sv
`default_nettype none

package rne_pkg;

    // Longest spelling kept for one number; anything beyond is dropped.
    localparam int unsigned MAX_CHARS = 15;

    localparam int unsigned SYM_W = 7;
    localparam int unsigned CNT_W = 4;

    // Letter indexes: one-symbol of digit e is 2e, five-symbol 2e+1, ten-symbol 2e+2.
    localparam logic [2:0] LTR_I = 3'd0;
    localparam logic [2:0] LTR_V = 3'd1;
    localparam logic [2:0] LTR_X = 3'd2;
    localparam logic [2:0] LTR_L = 3'd3;
    localparam logic [2:0] LTR_C = 3'd4;
    localparam logic [2:0] LTR_D = 3'd5;
    localparam logic [2:0] LTR_M = 3'd6;

    localparam logic [1:0] DIG_THOUSANDS = 2'd3;

    // Decimal digits of one number, units in dig[0], thousands in dig[3].
    typedef struct packed {
        logic            is_zero;
        logic [3:0][3:0] dig;
    } t_digits;

    function automatic logic [SYM_W-1:0] letter(input logic [2:0] idx);
        logic [SYM_W-1:0] ch;
        case (idx)
            LTR_I:   ch = 7'h49;
            LTR_V:   ch = 7'h56;
            LTR_X:   ch = 7'h58;
            LTR_L:   ch = 7'h4C;
            LTR_C:   ch = 7'h43;
            LTR_D:   ch = 7'h44;
            LTR_M:   ch = 7'h4D;
            default: ch = 7'h3F;
        endcase
        return ch;
    endfunction

    // Characters needed for a hundreds, tens or units digit.
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/rne_front.sv
`default_nettype none

module rne_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [11:0]      i_number,
    output logic                  o_q_push,
    output rne_pkg::t_digits      o_q_data,
    input  wire logic             i_q_full
);

    logic             r_s1_v;
    logic [2:0]       r_s1_th;
    logic [9:0]       r_s1_rem;
    logic             r_s1_zero;
    logic             r_s2_v;
    rne_pkg::t_digits r_s2;

    logic [2:0]       th;
    logic [9:0]       rem;
    logic [3:0]       hun;
    logic [6:0]       rem2;
    logic [3:0]       ten;
    logic [3:0]       unit;
    rne_pkg::t_digits n_s2;

    logic s2_move, s2_free, s1_move, s1_free, accept;

    assign s2_move  = r_s2_v && !i_q_full;
    assign s2_free  = !r_s2_v || s2_move;
    assign s1_move  = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || s1_move;
    assign accept   = push && s1_free;
    assign full     = !s1_free;
    assign o_q_push = s2_move;
    assign o_q_data = r_s2;

    // Thousands digit by a compare ladder, then strip it off.
    always_comb begin
        th = '0;
        for (int k = 1; k <= 4; k++) begin
            th = th + 3'(i_number >= 12'(1000 * k));
        end
        rem = 10'(i_number - 12'(th) * 12'd1000);
    end

    always_comb begin
        hun = '0;
        for (int k = 1; k <= 9; k++) begin
            hun = hun + 4'(r_s1_rem >= 10'(100 * k));
        end
        rem2 = 7'(r_s1_rem - 10'(hun) * 10'd100);
        ten = '0;
        for (int k = 1; k <= 9; k++) begin
            ten = ten + 4'(rem2 >= 7'(10 * k));
        end
        unit = 4'(rem2 - 7'(ten) * 7'd10);
        n_s2.is_zero = r_s1_zero;
        n_s2.dig[3]  = {1'b0, r_s1_th};
        n_s2.dig[2]  = hun;
        n_s2.dig[1]  = ten;
        n_s2.dig[0]  = unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (s2_move) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_th   <= th;
            r_s1_rem  <= rem;
            r_s1_zero <= (i_number == '0);
        end
        if (s1_move) begin
            r_s2 <= n_s2;
        end
    end

`ifndef SYNTHESIS
    a_stage2_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_s2.dig[2] <= 4'd9 && r_s2.dig[1] <= 4'd9 && r_s2.dig[0] <= 4'd9))
        else $error("decimal digit out of range");
    a_stage1_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> r_s1_rem < 10'd1000)
        else $error("thousands remainder out of range");
    a_full_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (r_s1_v && r_s2_v && i_q_full))
        else $error("front reports full without a blocked pipeline");
`endif

endmodule

`default_nettype wire

// File: hdl/rne_queue.sv
`default_nettype none

module rne_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rne_pkg::t_digits i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output rne_pkg::t_digits      o_data,
    output logic                  o_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rne_pkg::t_digits r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_ptrs_match_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// File: hdl/rne_speller.sv
`default_nettype none

module rne_speller (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire rne_pkg::t_digits            i_q_data,
    output logic                             o_q_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [rne_pkg::SYM_W-1:0]        o_symbol,
    output logic                             o_last_symbol,
    output logic                             o_empty_res
);

    logic                         r_busy;
    logic                         r_zero;
    logic [3:0][3:0]              r_dig;
    logic [1:0]                   r_e;
    logic [1:0]                   r_j;
    logic [rne_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_out_v;
    logic [rne_pkg::SYM_W-1:0]    r_out_sym;
    logic                         r_out_last;
    logic                         r_out_empty;

    logic [3:0]                   d;
    logic [2:0]                   dlen;
    logic [2:0]                   one_idx;
    logic [2:0]                   sel_idx;
    logic                         digit_end;
    logic                         found;
    logic [1:0]                   next_e;
    logic                         emit_last;
    logic                         adv;
    logic                         emit;
    logic                         take;

    function automatic logic [1:0] top_digit(input rne_pkg::t_digits x);
        logic [1:0] idx;
        idx = '0;
        for (int k = 0; k < 4; k++) begin
            if (x.dig[k] != '0) begin
                idx = 2'(k);
            end
        end
        return idx;
    endfunction

    assign adv  = !r_out_v || pop;
    assign emit = r_busy && adv;
    assign take = i_q_valid && (!r_busy || (emit && emit_last));

    assign o_q_pop       = take;
    assign empty         = !r_out_v;
    assign o_symbol      = r_out_sym;
    assign o_last_symbol = r_out_last;
    assign o_empty_res   = r_out_empty;

    always_comb begin
        d       = r_dig[r_e];
        one_idx = {r_e, 1'b0};
        if (r_e == rne_pkg::DIG_THOUSANDS) begin
            dlen    = d[2:0];
            sel_idx = one_idx;
        end else begin
            dlen = rne_pkg::digit_len(d);
            // Subtractive forms for four and nine, otherwise optional five then ones.
            if (d == 4'd9) begin
                sel_idx = (r_j == '0) ? one_idx : one_idx + 3'd2;
            end else if (d == 4'd4) begin
                sel_idx = (r_j == '0) ? one_idx : one_idx + 3'd1;
            end else if (d >= 4'd5 && r_j == '0) begin
                sel_idx = one_idx + 3'd1;
            end else begin
                sel_idx = one_idx;
            end
        end
        digit_end = (3'(r_j) + 3'd1 == dlen);

        found  = 1'b0;
        next_e = '0;
        for (int k = 2; k >= 0; k--) begin
            if (!found && 2'(k) < r_e && r_dig[k] != '0) begin
                found  = 1'b1;
                next_e = 2'(k);
            end
        end

        emit_last = r_zero || (digit_end && !found) ||
                    (r_cnt == rne_pkg::CNT_W'(rne_pkg::MAX_CHARS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv) begin
                r_out_v <= r_busy;
            end
            if (emit && emit_last) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_sym   <= r_zero ? '0 : rne_pkg::letter(sel_idx);
            r_out_last  <= emit_last;
            r_out_empty <= r_zero;
            r_cnt       <= r_cnt + 1'b1;
            if (digit_end) begin
                r_e <= next_e;
                r_j <= '0;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        // A new beat from the queue overrides the finished item's position.
        if (take) begin
            r_zero <= i_q_data.is_zero;
            r_dig  <= i_q_data.dig;
            r_e    <= top_digit(i_q_data);
            r_j    <= '0;
            r_cnt  <= '0;
        end
    end

`ifndef SYNTHESIS
    a_empty_beat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_empty) |-> (r_out_last && r_out_sym == '0))
        else $error("empty result without last mark or with a character");
    a_digit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_zero) |-> (d != '0 && 3'(r_j) < dlen))
        else $error("speller positioned outside a nonzero digit");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < rne_pkg::CNT_W'(rne_pkg::MAX_CHARS))
        else $error("character count beyond spelling limit");
    a_emit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_v)
        else $error("emitted character not held in output register");
`endif

endmodule

`default_nettype wire

// File: hdl/roman_numeral_encoder_unit.sv
// Roman numeral encoder: spells a 12-bit unsigned number as ASCII numeral characters.
// Input channel: drive i_number with push high; the beat is taken when full is low.
// Result channel: while empty is low, o_symbol, o_last_symbol and o_empty_res show
// the oldest character; pop high takes it. o_last_symbol marks the final character
// of a number; zero gives a single beat with o_empty_res set and o_symbol zero.
// Values from 4000 up lead with MMMM; spellings are cut at fifteen characters.
// Path: the first character of a number passes two digit-extraction stages, the digit
// queue, the speller's digit registers and the spelling register.
// Throughput: one character per cycle on the result side while the receiver pops;
// the spelling sequencer and its single output register set that rate. The front
// accepts a number every cycle until the digit queue (QUEUE_DEPTH entries) and its
// two stages fill up.
// When the receiver stalls, the output register holds its character, the sequencer
// waits, and full rises once the queue and front stages are occupied.
// Reset (synchronous, i_rst_n low) empties the stages, the queue and the output.
`default_nettype none

module roman_numeral_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [11:0]                 i_number,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [rne_pkg::SYM_W-1:0]        o_symbol,
    output logic                             o_last_symbol,
    output logic                             o_empty_res
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    rne_pkg::t_digits q_wdata;
    rne_pkg::t_digits q_rdata;

    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_number (i_number),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_valid (q_valid)
    );

    rne_speller u_speller (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_symbol      (o_symbol),
        .o_last_symbol (o_last_symbol),
        .o_empty_res   (o_empty_res)
    );

endmodule

`default_nettype wire
